// File: hw/rtl/relative_strength_index_defines.svh
// Assertion macros for the relative strength index block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef RELATIVE_STRENGTH_INDEX_DEFINES_SVH
`define RELATIVE_STRENGTH_INDEX_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsi: same-cycle check failed");
// next-cycle implication
`define RSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsi: next-cycle check failed");
`else
`define RSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/rsi_pkg.sv
// Shared constants and controller/datapath command and status types for the RSI block.
// No dependencies.
package rsi_pkg;

	localparam int CLOSE_BITS   = 32;   // width of the close_px field
	localparam int PRICE_BITS   = 32;   // price bits actually used
	localparam int FRAC_BITS    = 8;    // extra fraction bits of the averages
	localparam int AVG_BITS     = 40;   // sums and averages
	localparam int PERIOD_BITS  = 8;
	localparam int COUNT_BITS   = PERIOD_BITS + 1;
	localparam int RSI_BITS     = 15;
	localparam int RSI_SCALE    = 100 * 256;
	localparam int SCALE_BITS   = 15;   // bits needed for RSI_SCALE
	localparam int PERIOD_RESET = 14;

	// dividend of the divide-by-period step: seed sum << F or avg*(p-1) + scaled change
	localparam int NUM_BITS   = ((FRAC_BITS > PERIOD_BITS) ? AVG_BITS + FRAC_BITS
		: AVG_BITS + PERIOD_BITS) + 1;
	localparam int STEP_BITS  = $clog2(NUM_BITS);
	localparam int PROD_BITS  = AVG_BITS + SCALE_BITS;
	localparam int TOTAL_BITS = AVG_BITS + 1;

	localparam logic [AVG_BITS-1:0] AVG_MAX = '1;

	typedef struct packed {
		logic take;    // latch the accepted request
		logic eval;    // split change, update count and warm-up sums
		logic load;    // form the two dividends
		logic pdiv;    // one restoring step of the divide by period
		logic save;    // write back saturated averages
		logic rload;   // form ratio dividend and divisor
		logic rdiv;    // one restoring step of the ratio divide
		logic push;    // load the output register
	} rsi_cmd_t;

	typedef struct packed {
		logic first;   // series restart, no result
		logic warm;    // still summing, no result
		logic flat;    // both averages zero
	} rsi_stat_t;

endpackage

// File: hw/rtl/rsi_if.sv
// Valid/ready channel interfaces for price requests and RSI results.
// Depends on rsi_pkg.
interface rsi_in_if import rsi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CLOSE_BITS-1:0] close_px;
	logic                  series_start;

	modport source (output valid, output close_px, output series_start, input ready);
	modport sink   (input valid, input close_px, input series_start, output ready);
endinterface

interface rsi_out_if import rsi_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [RSI_BITS-1:0] rsi_value;
	logic                no_movement;

	modport source (output valid, output rsi_value, output no_movement, input ready);
	modport sink   (input valid, input rsi_value, input no_movement, output ready);
endinterface

// File: hw/rtl/rsi_ctrl.sv
// Sequencer of the RSI block: steps the datapath through one request at a time.
// Depends on rsi_pkg and relative_strength_index_defines.svh.
`include "relative_strength_index_defines.svh"

module rsi_ctrl import rsi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rsi_stat_t stat,
	output rsi_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_EVAL, S_LOAD, S_PDIV, S_SAVE, S_RLOAD, S_RDIV, S_PUSH
	} state_t;

	state_t               state_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.take  = (state_q == S_IDLE) && in_valid;
		cmd.eval  = (state_q == S_EVAL);
		cmd.load  = (state_q == S_LOAD);
		cmd.pdiv  = (state_q == S_PDIV);
		cmd.save  = (state_q == S_SAVE);
		cmd.rload = (state_q == S_RLOAD);
		cmd.rdiv  = (state_q == S_RDIV);
		cmd.push  = (state_q == S_PUSH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (stat.first || stat.warm) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_PDIV;
					cnt_q   <= STEP_BITS'(NUM_BITS - 1);
				end
				S_PDIV: begin
					if (cnt_q == '0) begin
						state_q <= S_SAVE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SAVE: begin
					state_q <= S_RLOAD;
				end
				S_RLOAD: begin
					if (stat.flat) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_RDIV;
						cnt_q   <= STEP_BITS'(RSI_BITS - 1);
					end
				end
				S_RDIV: begin
					if (cnt_q == '0) begin
						state_q <= S_PUSH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_PUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RSI_ASSERT_NXT(a_take_to_eval, clk, arst_n, in_valid && in_ready, state_q == S_EVAL)
	`RSI_ASSERT_IMP(a_valid_from_push, clk, arst_n, $rose(out_valid_q), $past(state_q == S_PUSH))
	`RSI_ASSERT_NXT(a_pdiv_exit, clk, arst_n, state_q == S_PDIV && cnt_q == '0, state_q == S_SAVE)
	`RSI_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0(cmd))

endmodule

// File: hw/rtl/rsi_dp.sv
// Datapath of the RSI block: series state, averages, two dividers, result register.
// Depends on rsi_pkg and relative_strength_index_defines.svh.
`include "relative_strength_index_defines.svh"

module rsi_dp import rsi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [PERIOD_BITS-1:0] cfg_wdata,
	input  logic [CLOSE_BITS-1:0]  close_px,
	input  logic                   series_start,
	input  rsi_cmd_t               cmd,
	output rsi_stat_t              stat,
	output logic [RSI_BITS-1:0]    rsi_value,
	output logic                   no_movement
);

	localparam int SCALED_BITS = (PRICE_BITS + FRAC_BITS > AVG_BITS) ?
		PRICE_BITS + FRAC_BITS : AVG_BITS;
	localparam int MUL_BITS = AVG_BITS + PERIOD_BITS;

	function automatic logic [AVG_BITS-1:0] sat_add(input logic [AVG_BITS-1:0] a,
		input logic [PRICE_BITS-1:0] b);
		logic [AVG_BITS:0] s;
		s = {1'b0, a} + (AVG_BITS+1)'(b);
		return s[AVG_BITS] ? AVG_MAX : s[AVG_BITS-1:0];
	endfunction

	function automatic logic [AVG_BITS-1:0] scale_change(input logic [PRICE_BITS-1:0] x);
		logic [SCALED_BITS-1:0] w;
		w = SCALED_BITS'(x) << FRAC_BITS;
		return (w > SCALED_BITS'(AVG_MAX)) ? AVG_MAX : AVG_BITS'(w);
	endfunction

	logic [PERIOD_BITS-1:0] period_q;
	logic                   have_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [PRICE_BITS-1:0]  prev_q, price_q, gain_q, loss_q;
	logic                   start_q;
	logic [AVG_BITS-1:0]    avg_g_q, avg_l_q;
	logic [NUM_BITS-1:0]    num_g_q, num_l_q;
	logic [PERIOD_BITS-1:0] rem_g_q, rem_l_q;
	logic [TOTAL_BITS-1:0]  total_q, rrem_q;
	logic [RSI_BITS-1:0]    rlow_q, rsi_value_q;
	logic                   no_move_q;

	logic [PERIOD_BITS-1:0] p_eff, pm1;
	logic                   up;
	logic [PRICE_BITS-1:0]  gain, loss;
	logic [COUNT_BITS:0]    cnt_inc, cnt_lim, k_full;
	logic                   seed;
	logic [MUL_BITS-1:0]    mul_g, mul_l;
	logic [PERIOD_BITS:0]   r2_g, r2_l;
	logic                   ge_g, ge_l;
	logic [PROD_BITS-1:0]   rprod;
	logic [TOTAL_BITS:0]    rr2;
	logic                   rge;

	assign p_eff = (period_q == '0) ? PERIOD_BITS'(1) : period_q;
	assign pm1   = p_eff - 1'b1;

	assign up   = (price_q >= prev_q);
	assign gain = up ? price_q - prev_q : '0;
	assign loss = up ? '0 : prev_q - price_q;

	// count saturates one past the period
	assign cnt_inc = {1'b0, count_q} + 1'b1;
	assign cnt_lim = (COUNT_BITS+1)'(p_eff) + 1'b1;
	assign k_full  = (cnt_inc > cnt_lim) ? cnt_lim : cnt_inc;

	assign stat.first = start_q || !have_q;
	assign stat.warm  = (k_full < (COUNT_BITS+1)'(p_eff));
	assign stat.flat  = (avg_g_q == '0) && (avg_l_q == '0);

	assign seed  = (count_q == COUNT_BITS'(p_eff));
	assign mul_g = MUL_BITS'(avg_g_q) * MUL_BITS'(pm1);
	assign mul_l = MUL_BITS'(avg_l_q) * MUL_BITS'(pm1);

	assign r2_g = {rem_g_q, num_g_q[NUM_BITS-1]};
	assign r2_l = {rem_l_q, num_l_q[NUM_BITS-1]};
	assign ge_g = (r2_g >= {1'b0, p_eff});
	assign ge_l = (r2_l >= {1'b0, p_eff});

	assign rprod = PROD_BITS'(avg_g_q) * PROD_BITS'(RSI_SCALE);
	assign rr2   = {rrem_q, rlow_q[RSI_BITS-1]};
	assign rge   = (rr2 >= {1'b0, total_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_BITS'(PERIOD_RESET);
			have_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (cmd.eval) begin
				have_q  <= 1'b1;
				count_q <= stat.first ? '0 : COUNT_BITS'(k_full);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			price_q <= close_px[PRICE_BITS-1:0];
			start_q <= series_start;
		end
		if (cmd.eval) begin
			prev_q <= price_q;
			gain_q <= gain;
			loss_q <= loss;
			if (stat.first) begin
				avg_g_q <= '0;
				avg_l_q <= '0;
			end else if (stat.warm) begin
				avg_g_q <= sat_add(avg_g_q, gain);
				avg_l_q <= sat_add(avg_l_q, loss);
			end
		end
		if (cmd.load) begin
			rem_g_q <= '0;
			rem_l_q <= '0;
			if (seed) begin
				num_g_q <= NUM_BITS'(sat_add(avg_g_q, gain_q)) << FRAC_BITS;
				num_l_q <= NUM_BITS'(sat_add(avg_l_q, loss_q)) << FRAC_BITS;
			end else begin
				num_g_q <= NUM_BITS'(mul_g) + NUM_BITS'(scale_change(gain_q));
				num_l_q <= NUM_BITS'(mul_l) + NUM_BITS'(scale_change(loss_q));
			end
		end
		if (cmd.pdiv) begin
			rem_g_q <= ge_g ? PERIOD_BITS'(r2_g - {1'b0, p_eff}) : PERIOD_BITS'(r2_g);
			rem_l_q <= ge_l ? PERIOD_BITS'(r2_l - {1'b0, p_eff}) : PERIOD_BITS'(r2_l);
			num_g_q <= {num_g_q[NUM_BITS-2:0], ge_g};
			num_l_q <= {num_l_q[NUM_BITS-2:0], ge_l};
		end
		if (cmd.save) begin
			avg_g_q <= (num_g_q > NUM_BITS'(AVG_MAX)) ? AVG_MAX : num_g_q[AVG_BITS-1:0];
			avg_l_q <= (num_l_q > NUM_BITS'(AVG_MAX)) ? AVG_MAX : num_l_q[AVG_BITS-1:0];
		end
		if (cmd.rload) begin
			// quotient fits in RSI_BITS, so the top part already sits below the divisor
			total_q <= {1'b0, avg_g_q} + {1'b0, avg_l_q};
			rrem_q  <= TOTAL_BITS'(rprod >> RSI_BITS);
			rlow_q  <= rprod[RSI_BITS-1:0];
		end
		if (cmd.rdiv) begin
			rrem_q <= rge ? TOTAL_BITS'(rr2 - {1'b0, total_q}) : TOTAL_BITS'(rr2);
			rlow_q <= {rlow_q[RSI_BITS-2:0], rge};
		end
		if (cmd.push) begin
			rsi_value_q <= stat.flat ? '0 : rlow_q;
			no_move_q   <= stat.flat;
		end
	end

	assign rsi_value   = rsi_value_q;
	assign no_movement = no_move_q;

	`RSI_ASSERT_IMP(a_rdiv_rem_below, clk, arst_n, cmd.rdiv, rrem_q < total_q)
	`RSI_ASSERT_IMP(a_pdiv_rem_below, clk, arst_n, cmd.pdiv, rem_g_q < p_eff && rem_l_q < p_eff)

endmodule

// File: hw/rtl/relative_strength_index.sv
// Wilder RSI over a stream of unsigned Q16.16 closing prices. Each price request
// yields at most one result: the first price of a series (series_start, or the first
// after reset) and the warm-up changes before change number `period` yield none. A
// request that yields a result goes from accept to the next accept through these
// steps: split the change, form the dividends, run 49 restoring steps of the
// divide-by-period unit (gain and loss lanes side by side), save the averages, form
// the ratio, run 15 restoring steps of the ratio divider and load the output register.
// When both averages are zero the ratio divide is skipped. A result still waiting in
// the output register holds back the load of the next one. rsi_value is
// floor(25600*gain/(gain+loss)); when both averages are zero it is 0 with no_movement
// set. The output register lets the next price be taken while a result still waits.
// period (reset 14, 0 acts as 1) is written through cfg_we/cfg_wdata and must only
// change while the block is idle; a new series is advised after a change.
// Depends on rsi_pkg, rsi_if, rsi_ctrl and rsi_dp.
module relative_strength_index import rsi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [PERIOD_BITS-1:0] cfg_wdata,
	rsi_in_if.sink                 price,
	rsi_out_if.source              rsi
);

	rsi_cmd_t  cmd;
	rsi_stat_t stat;

	// sequencer: handshakes and step counting
	rsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (price.valid),
		.in_ready  (price.ready),
		.out_valid (rsi.valid),
		.out_ready (rsi.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// state, averages, dividers and the result register
	rsi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.close_px     (price.close_px),
		.series_start (price.series_start),
		.cmd          (cmd),
		.stat         (stat),
		.rsi_value    (rsi.rsi_value),
		.no_movement  (rsi.no_movement)
	);

endmodule
